// ===== hdl/pc_pkg.sv =====
// Shared types, constants and character helpers for the percent codec.
package pc_pkg;

    // Character codes
    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;

    // Configuration register indexes
    localparam logic REG_MODE       = 1'b0;
    localparam logic REG_PASS_SLASH = 1'b1;

    // Mode codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Byte groups buffered between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // Most bytes one input item can produce
    localparam int MAX_OUT = 3;

    // Escape tracking in decode mode
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // One classified item: up to three bytes to send, last mark on the final one
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
        logic            last;
    } entry_t;

    // Unreserved set: A-Z a-z 0-9 - . _ ~
    function automatic logic is_unreserved(logic [7:0] c);
        logic r;
        r = (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]}) ||
            (c inside {[8'h30:8'h39]}) ||
            (c inside {8'h2D, 8'h2E, 8'h5F, 8'h7E});
        return r;
    endfunction

    // Hex digit value; bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [4:0] v;
        if (c inside {[8'h30:8'h39]})
            v = 5'(c - 8'h30);
        else if (c inside {[8'h61:8'h66]})
            v = 5'(c - 8'h57);
        else if (c inside {[8'h41:8'h46]})
            v = 5'(c - 8'h37);
        else
            v = 5'h10;
        return v;
    endfunction

    // Uppercase hex character for a nibble
    function automatic logic [7:0] hex_char(logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10)
            c = 8'h30 + {4'h0, n};
        else
            c = 8'h37 + {4'h0, n};
        return c;
    endfunction

endpackage

// ===== hdl/pc_in_if.sv =====
// Input channel: one string byte per beat with a last mark.
interface pc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hdl/pc_out_if.sv =====
// Output channel: one coded byte per beat with a last mark.
interface pc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== hdl/pc_front.sv =====
// Front end: accepts input bytes, tracks escapes and builds byte groups.
module pc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          mode,
    input  logic          pass_slash,
    input  logic          queue_full,
    pc_in_if.sink         din,
    output logic          push,
    output pc_pkg::entry_t push_entry
);

    pc_pkg::phase_t phase_reg, phase_next;
    logic [7:0]     held_reg, held_next;

    logic           accept;
    logic [7:0]     b;
    logic [4:0]     hv_b;
    logic [4:0]     hv_held;
    logic [7:0]     esc_val;
    logic [1:0]     n_v;
    logic [2:0][7:0] bytes_v;

    assign din.ready = !queue_full;
    assign accept    = din.valid && din.ready;
    assign b         = din.in_byte;
    assign hv_b      = pc_pkg::hex_value(b);
    assign hv_held   = pc_pkg::hex_value(held_reg);
    assign esc_val   = {hv_held[3:0], hv_b[3:0]};

    // Classify one byte into up to three output bytes
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        n_v        = 2'd0;
        bytes_v    = '0;
        if (mode == pc_pkg::MODE_ENCODE)
        begin
            phase_next = pc_pkg::PH_IDLE;
            held_next  = 8'h00;
            if (pc_pkg::is_unreserved(b) || (pass_slash && b == pc_pkg::SLASH_CHAR))
            begin
                bytes_v[0] = b;
                n_v        = 2'd1;
            end
            else
            begin
                bytes_v[0] = pc_pkg::PCT_CHAR;
                bytes_v[1] = pc_pkg::hex_char(b[7:4]);
                bytes_v[2] = pc_pkg::hex_char(b[3:0]);
                n_v        = 2'd3;
            end
        end
        else
        begin
            case (phase_reg)
                pc_pkg::PH_PCT:
                begin
                    if (!hv_b[4])
                    begin
                        held_next  = b;
                        phase_next = pc_pkg::PH_DIGIT;
                    end
                    else
                    begin
                        // malformed: literal percent, then the byte afresh
                        bytes_v[0] = pc_pkg::PCT_CHAR;
                        n_v        = 2'd1;
                        if (b == pc_pkg::PCT_CHAR)
                            phase_next = pc_pkg::PH_PCT;
                        else
                        begin
                            phase_next = pc_pkg::PH_IDLE;
                            bytes_v[1] = b;
                            n_v        = 2'd2;
                        end
                    end
                end
                pc_pkg::PH_DIGIT:
                begin
                    if (!hv_b[4] && esc_val != 8'h00)
                    begin
                        bytes_v[0] = esc_val;
                        n_v        = 2'd1;
                        phase_next = pc_pkg::PH_IDLE;
                    end
                    else
                    begin
                        // bad second digit or zero escape: keep it verbatim
                        bytes_v[0] = pc_pkg::PCT_CHAR;
                        bytes_v[1] = held_reg;
                        n_v        = 2'd2;
                        if (b == pc_pkg::PCT_CHAR)
                            phase_next = pc_pkg::PH_PCT;
                        else
                        begin
                            phase_next = pc_pkg::PH_IDLE;
                            bytes_v[2] = b;
                            n_v        = 2'd3;
                        end
                    end
                end
                default:
                begin
                    if (b == pc_pkg::PCT_CHAR)
                        phase_next = pc_pkg::PH_PCT;
                    else
                    begin
                        phase_next = pc_pkg::PH_IDLE;
                        bytes_v[0] = b;
                        n_v        = 2'd1;
                    end
                end
            endcase

            // flush a pending escape on the final byte
            if (din.in_last)
            begin
                if (phase_next == pc_pkg::PH_PCT || phase_next == pc_pkg::PH_DIGIT)
                begin
                    if (n_v != 2'd3)
                    begin
                        bytes_v[n_v] = pc_pkg::PCT_CHAR;
                        n_v          = n_v + 2'd1;
                    end
                end
                if (phase_next == pc_pkg::PH_DIGIT)
                begin
                    if (n_v != 2'd3)
                    begin
                        bytes_v[n_v] = held_next;
                        n_v          = n_v + 2'd1;
                    end
                end
                phase_next = pc_pkg::PH_IDLE;
                held_next  = 8'h00;
            end
        end
    end

    // Escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pc_pkg::PH_IDLE;
            held_reg  <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // Groups with no bytes never enter the queue
    assign push             = accept && (n_v != 2'd0);
    assign push_entry.count = n_v;
    assign push_entry.bytes = bytes_v;
    assign push_entry.last  = din.in_last;

endmodule

// ===== hdl/pc_queue.sv =====
// Small FIFO of byte groups between the front and the back.
module pc_queue #(
    parameter int DEPTH = pc_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pc_pkg::entry_t push_entry,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output pc_pkg::entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pc_pkg::entry_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== hdl/pc_back.sv =====
// Back end: serializes byte groups into single output beats.
module pc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  pc_pkg::entry_t head_entry,
    output logic           pop,
    pc_out_if.source       dout
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       load;
    logic       final_byte;

    assign load       = head_valid && (!out_valid_reg || dout.ready);
    assign final_byte = (idx_reg == head_entry.count - 2'd1);
    assign pop        = load && final_byte;

    // Byte index within the current group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else if (load)
            idx_reg <= final_byte ? 2'd0 : idx_reg + 2'd1;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (dout.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= head_entry.bytes[idx_reg];
            out_last_reg <= head_entry.last && final_byte;
        end
    end

    assign dout.valid    = out_valid_reg;
    assign dout.out_byte = out_byte_reg;
    assign dout.out_last = out_last_reg;

endmodule

// ===== hdl/percent_codec_core.sv =====
// Percent codec: input bytes in, escaped or unescaped bytes out, one per beat.
// An input beat's byte group goes into the queue, then byte by byte into the output register.
// Throughput: one input byte per cycle while each yields one byte and dout is ready; a stream
// of bytes that expand to three is held to the pace of the back once the two-entry queue fills.
// Reset: escape state clears, the queue and output register empty, mode and pass_slash go to 0.
module percent_codec_core #(
    parameter int QUEUE_DEPTH = pc_pkg::QUEUE_DEPTH
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  logic     wr_index,
    input  logic     wr_data,
    pc_in_if.sink    din,
    pc_out_if.source dout
);

    logic           mode_reg;
    logic           pass_slash_reg;
    logic           queue_full;
    logic           push;
    logic           pop;
    logic           head_valid;
    pc_pkg::entry_t push_entry;
    pc_pkg::entry_t head_entry;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= pc_pkg::MODE_ENCODE;
            pass_slash_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                pc_pkg::REG_MODE:       mode_reg       <= wr_data;
                pc_pkg::REG_PASS_SLASH: pass_slash_reg <= wr_data;
                default:                ;
            endcase
        end
    end

    pc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .pass_slash (pass_slash_reg),
        .queue_full (queue_full),
        .din        (din),
        .push       (push),
        .push_entry (push_entry)
    );

    pc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    pc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .dout       (dout)
    );

endmodule

// ===== tb/percent_codec_core_test.sv =====
// Self-checking testbench for the percent codec core: encode, decode, mode changes, backpressure.
`timescale 1ns / 100ps

module percent_codec_core_test;

    localparam int STALL_LIMIT  = 1000;   // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 4;      // settle time after the last expected output beat
    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_HOLD    = 80;
    localparam logic [4:0] NOT_HEX = 5'd16;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } coded_beat_t;

    typedef enum int {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE
    } rx_pattern_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic wr_index;
    logic wr_data;

    pc_in_if  din_if ();
    pc_out_if dout_if ();

    percent_codec_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .din      (din_if),
        .dout     (dout_if)
    );

    // Mirror of the codec registers and escape state
    logic           cfg_mode       = pc_pkg::MODE_ENCODE;
    logic           cfg_pass_slash = 1'b0;
    pc_pkg::phase_t esc_phase      = pc_pkg::PH_IDLE;
    logic [7:0]     esc_digit      = 8'h00;
    coded_beat_t    coded_beats[$];

    int error_count   = 0;
    int quiet_cycles  = 0;
    int out_beat_no   = 0;
    int tx_burst_left = 0;
    bit tx_bursty     = 1'b1;
    bit rx_hold_req   = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Character helpers
    function automatic bit plain_char(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
               c == "-" || c == "." || c == "_" || c == "~";
    endfunction

    function automatic logic [4:0] nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 5'(c - "0");
        if (c >= "a" && c <= "f")
            return 5'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F")
            return 5'(c - "A" + 8'd10);
        return NOT_HEX;
    endfunction

    function automatic logic [7:0] hex_upper(logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h41 + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] rand_hex_digit();
        logic [3:0] v;
        v = 4'($urandom_range(0, 15));
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (nibble_of(c) != NOT_HEX)
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    // Expected output beats for one accepted input beat
    task automatic predict_coded(input logic [7:0] b, input logic last);
        coded_beat_t beats[3];
        int          n;
        logic        refeed;
        logic [4:0]  lo;
        logic [4:0]  hi;
        logic [7:0]  val;
        n = 0;
        refeed = 1'b0;
        if (cfg_mode == pc_pkg::MODE_ENCODE)
        begin
            // encoding drops any escape left over from decode
            esc_phase = pc_pkg::PH_IDLE;
            esc_digit = 8'h00;
            if (plain_char(b) || (cfg_pass_slash && b == pc_pkg::SLASH_CHAR))
            begin
                beats[0] = '{b, 1'b0};
                n = 1;
            end
            else
            begin
                beats[0] = '{pc_pkg::PCT_CHAR, 1'b0};
                beats[1] = '{hex_upper(b[7:4]), 1'b0};
                beats[2] = '{hex_upper(b[3:0]), 1'b0};
                n = 3;
            end
        end
        else
        begin
            lo = nibble_of(b);
            case (esc_phase)
                pc_pkg::PH_PCT:
                begin
                    if (!lo[4])
                    begin
                        esc_digit = b;
                        esc_phase = pc_pkg::PH_DIGIT;
                    end
                    else
                    begin
                        beats[n] = '{pc_pkg::PCT_CHAR, 1'b0};
                        n++;
                        refeed = 1'b1;
                    end
                end
                pc_pkg::PH_DIGIT:
                begin
                    hi = nibble_of(esc_digit);
                    val = {hi[3:0], lo[3:0]};
                    if (!lo[4] && val != 8'h00)
                    begin
                        beats[n] = '{val, 1'b0};
                        n++;
                        esc_phase = pc_pkg::PH_IDLE;
                    end
                    else
                    begin
                        // malformed or zero escape goes out verbatim
                        beats[n] = '{pc_pkg::PCT_CHAR, 1'b0};
                        n++;
                        beats[n] = '{esc_digit, 1'b0};
                        n++;
                        refeed = 1'b1;
                    end
                end
                default:
                    refeed = 1'b1;
            endcase
            // byte handled as if no escape were pending
            if (refeed)
            begin
                if (b == pc_pkg::PCT_CHAR)
                    esc_phase = pc_pkg::PH_PCT;
                else
                begin
                    esc_phase = pc_pkg::PH_IDLE;
                    beats[n] = '{b, 1'b0};
                    n++;
                end
            end
            // flush a pending escape at end of string
            if (last)
            begin
                if (esc_phase != pc_pkg::PH_IDLE)
                begin
                    beats[n] = '{pc_pkg::PCT_CHAR, 1'b0};
                    n++;
                end
                if (esc_phase == pc_pkg::PH_DIGIT)
                begin
                    beats[n] = '{esc_digit, 1'b0};
                    n++;
                end
                esc_phase = pc_pkg::PH_IDLE;
            end
        end
        if (last && n > 0)
        begin
            esc_digit = 8'h00;
            beats[n - 1].last = 1'b1;
        end
        for (int i = 0; i < n; i++)
            coded_beats.push_back(beats[i]);
    endtask

    // Predict on every input beat, check every output beat
    always @(posedge clk)
    begin
        coded_beat_t want;
        if (rst_n)
        begin
            if (din_if.valid && din_if.ready)
                predict_coded(din_if.in_byte, din_if.in_last);
            if (dout_if.valid && dout_if.ready)
            begin
                if (coded_beats.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("out beat %0d: unexpected byte %02h last %0b",
                                 out_beat_no, dout_if.out_byte, dout_if.out_last);
                end
                else
                begin
                    want = coded_beats.pop_front();
                    if (dout_if.out_byte !== want.data || dout_if.out_last !== want.last)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("out beat %0d: expected %02h last %0b, got %02h last %0b",
                                     out_beat_no, want.data, want.last,
                                     dout_if.out_byte, dout_if.out_last);
                    end
                end
                out_beat_no++;
            end
        end
    end

    // Watchdog: too long without any beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[percent_codec_core] ERROR");
                $finish;
            end
        end
    end

    // Output side: changing stall patterns, plus a long hold-off on request
    initial
    begin
        int          hold_left;
        int          pat_left;
        rx_pattern_t pat_kind;
        hold_left = 0;
        pat_left = 0;
        pat_kind = RX_ALWAYS;
        dout_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dout_if.ready <= 1'b0;
            end
            else
            begin
                if (pat_left == 0)
                begin
                    pat_kind = rx_pattern_t'($urandom_range(RX_ALWAYS, RX_SPARSE));
                    pat_left = $urandom_range(8, 40);
                end
                pat_left--;
                case (pat_kind)
                    RX_ALWAYS: dout_if.ready <= 1'b1;
                    RX_HALF:   dout_if.ready <= ($urandom_range(0, 1) != 0);
                    default:   dout_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one input beat and wait until it is taken; bursts with random gaps while tx_bursty is set
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (tx_burst_left == 0)
        begin
            tx_burst_left = $urandom_range(1, 16);
            gap = tx_bursty ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                din_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        tx_burst_left--;
        din_if.valid <= 1'b1;
        din_if.in_byte <= b;
        din_if.in_last <= last;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // Stop sending, let every expected beat arrive, then give the core time to settle
    task automatic wait_idle();
        din_if.valid <= 1'b0;
        while (coded_beats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write both registers; only called while the core is idle
    task automatic configure(input logic m, input logic ks);
        wr_en <= 1'b1;
        wr_index <= pc_pkg::REG_MODE;
        wr_data <= m;
        @(negedge clk);
        wr_index <= pc_pkg::REG_PASS_SLASH;
        wr_data <= ks;
        @(negedge clk);
        wr_en <= 1'b0;
        cfg_mode = m;
        cfg_pass_slash = ks;
    endtask

    task automatic test_encode_basics();
        wait_idle();
        configure(pc_pkg::MODE_ENCODE, 1'b0);
        // unreserved set passes, slash and space get escaped
        send_text("Az9-._~/ ");
        // top of the byte range, then 01 just above the bottom
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);
        wait_idle();
        configure(pc_pkg::MODE_ENCODE, 1'b1);
        send_text("/");
    endtask

    task automatic test_decode_escapes();
        wait_idle();
        configure(pc_pkg::MODE_DECODE, 1'b0);
        // good escape, zero escape kept, bad digit, bad second digit, lone percent at end
        send_text("%4a%00%G%4%");
        // held digit flushed at end of string
        send_text("%f");
    endtask

    task automatic test_pending_escape_dropped();
        wait_idle();
        configure(pc_pkg::MODE_DECODE, 1'b0);
        send_byte(pc_pkg::PCT_CHAR, 1'b0);
        wait_idle();
        configure(pc_pkg::MODE_ENCODE, 1'b0);
        send_byte("a", 1'b1);
    endtask

    task automatic test_output_hold();
        wait_idle();
        configure(pc_pkg::MODE_ENCODE, 1'b0);
        tx_bursty = 1'b0;
        rx_hold_req = 1'b1;
        // every space expands to three beats, so the core backs up fast
        for (int i = 0; i < 24; i++)
            send_byte(" ", i == 23);
        wait_idle();
        tx_bursty = 1'b1;
    endtask

    task automatic test_random_streams();
        int         sent;
        int         phase_no;
        int         phase_end;
        int         n_el;
        logic       m;
        logic       ks;
        logic [7:0] text[$];
        string      plain_set;
        plain_set = "AZaz09-._~";
        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // first four phases walk every register setting
            if (phase_no < 4)
            begin
                m = phase_no[0];
                ks = phase_no[1];
            end
            else
            begin
                m = 1'($urandom_range(0, 1));
                ks = 1'($urandom_range(0, 1));
            end
            wait_idle();
            configure(m, ks);
            tx_bursty = ($urandom_range(0, 3) != 0);
            phase_end = sent + $urandom_range(30, 70);
            while (sent < phase_end)
            begin
                text.delete();
                n_el = $urandom_range(1, 6);
                repeat (n_el)
                begin
                    if (m == pc_pkg::MODE_ENCODE)
                    begin
                        case ($urandom_range(0, 3))
                            0: text.push_back(8'($urandom_range(1, 255)));
                            1: text.push_back(plain_set[$urandom_range(0, plain_set.len() - 1)]);
                            2: text.push_back(pc_pkg::SLASH_CHAR);
                            default: text.push_back(pc_pkg::PCT_CHAR);
                        endcase
                    end
                    else
                    begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3:
                            begin
                                text.push_back(pc_pkg::PCT_CHAR);
                                text.push_back(rand_hex_digit());
                                text.push_back(rand_hex_digit());
                            end
                            4:
                            begin
                                text.push_back(pc_pkg::PCT_CHAR);
                                text.push_back("0");
                                text.push_back("0");
                            end
                            5, 6:
                                text.push_back(8'($urandom_range(1, 255)));
                            7:
                            begin
                                text.push_back(pc_pkg::PCT_CHAR);
                                text.push_back(rand_non_hex());
                            end
                            8:
                            begin
                                text.push_back(pc_pkg::PCT_CHAR);
                                text.push_back(rand_hex_digit());
                                text.push_back(rand_non_hex());
                            end
                            default:
                                text.push_back(pc_pkg::PCT_CHAR);
                        endcase
                    end
                end
                foreach (text[i])
                    send_byte(text[i], i == text.size() - 1);
                sent += text.size();
            end
            phase_no++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = pc_pkg::REG_MODE;
        wr_data = 1'b0;
        din_if.valid = 1'b0;
        din_if.in_byte = 8'h01;
        din_if.in_last = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_encode_basics();
        test_decode_escapes();
        test_pending_escape_dropped();
        test_output_hold();
        test_random_streams();
        wait_idle();

        if (error_count == 0 && coded_beats.size() == 0)
            $display("[percent_codec_core] OK");
        else
            $display("[percent_codec_core] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pc_pkg.sv
hdl/pc_in_if.sv
hdl/pc_out_if.sv
hdl/pc_front.sv
hdl/pc_queue.sv
hdl/pc_back.sv
hdl/percent_codec_core.sv
tb/percent_codec_core_test.sv
